FILE: src/hamming_encode_correct_unit_macros.svh
// assertion macros for the hamming encode/correct unit
// expects clk and arst_n in the scope of each use
`ifndef HAMMING_ENCODE_CORRECT_UNIT_MACROS_SVH
`define HAMMING_ENCODE_CORRECT_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define HEC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hec assertion failed");

// next-cycle implication
`define HEC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hec assertion failed");

`else

`define HEC_ASSERT_IMPL(label, ante, cons)
`define HEC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: src/hec_pkg.sv
// types, widths and code helper functions for the hamming encode/correct unit
// no dependencies
`default_nettype none

package hec_pkg;

	localparam int WORD_W = 31;
	localparam int POS_W  = 5;
	localparam int R_W    = 3;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [POS_W-1:0]  pos_t;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	// smallest r with 2^r >= m + r + 1
	function automatic logic [R_W-1:0] parity_count(input pos_t m);
		logic [R_W-1:0] r;
		r = '0;
		for (int i = 0; i < 7; i++) begin
			if ((7'd1 << r) < (7'(m) + 7'(r) + 7'd1))
				r = r + 3'd1;
		end
		return r;
	endfunction

	function automatic bit is_pow2(input int p);
		return (p & (p - 1)) == 0;
	endfunction

	// largest data length whose codeword fits in lim bits
	function automatic int max_data_bits(input int lim);
		int best;
		best = 1;
		for (int m = 1; m <= 26; m++) begin
			if (m + int'(parity_count(pos_t'(m))) <= lim)
				best = m;
		end
		return best;
	endfunction

	// xor of the 1-based indices of all set positions
	function automatic pos_t syndrome(input word_t cw);
		pos_t s;
		s = '0;
		for (int p = 1; p <= WORD_W; p++) begin
			if (cw[p-1])
				s = s ^ pos_t'(p);
		end
		return s;
	endfunction

	// data bits into the non-power-of-two positions, ascending
	function automatic word_t scatter(input word_t data);
		word_t cw;
		int    k;
		cw = '0;
		k  = 0;
		for (int p = 1; p <= WORD_W; p++) begin
			if (!is_pow2(p)) begin
				cw[p-1] = data[k];
				k = k + 1;
			end
		end
		return cw;
	endfunction

endpackage

`default_nettype wire

FILE: src/hamming_encode_correct_unit.sv
// hamming single-error-correcting encoder and corrector, top level
// depends on hec_pkg and hamming_encode_correct_unit_macros.svh
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, operation, word_in    | into block
//  out     | out_valid, out_stall, word_out,           | out of block
//          | error_position, error_found               |
//  cfg     | cfg_valid, cfg_ready, data_bits           | into block
//
// one item per cycle sustained while out_stall is low; each item passes the input register,
// then the xor trees into the result register, which drives out_valid
// arst_n clears the valid flags and sets the stored data length to 4 (7-bit codeword),
// clamped like a written length when MAX_CODE_BITS is below 7
// a held result stalls the input register, and its stall reaches in_stall
// cfg_ready is high only while no item is in flight
`default_nettype none
`include "hamming_encode_correct_unit_macros.svh"

module hamming_encode_correct_unit #(
	parameter int MAX_CODE_BITS = 31
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               operation,
	input  wire hec_pkg::word_t     word_in,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output hec_pkg::word_t          word_out,
	output hec_pkg::pos_t           error_position,
	output logic                    error_found,
	// configuration write
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire hec_pkg::pos_t      data_bits
);

	import hec_pkg::*;

	// codeword length limit and the data length it allows
	localparam int CODE_LIMIT = (MAX_CODE_BITS < WORD_W) ? MAX_CODE_BITS : WORD_W;
	localparam int M_MAX      = max_data_bits(CODE_LIMIT);

	// reset length of four data bits, saturated to what fits
	localparam pos_t RESET_M = pos_t'((M_MAX < 4) ? M_MAX : 4);
	localparam pos_t RESET_N = RESET_M + pos_t'(parity_count(RESET_M));

	// configuration: effective data length and code length
	pos_t m_q;
	pos_t n_q;
	pos_t cfg_m;
	pos_t cfg_m_clip;
	pos_t cfg_n;

	// input register
	logic  valid_s1;
	op_t   op_s1;
	word_t word_s1;

	// result register
	logic  out_valid_q;
	word_t word_q;
	pos_t  pos_q;
	logic  found_q;

	logic  out_take;
	logic  adv_s1;

	// datapath
	word_t m_mask;
	word_t n_mask;
	word_t enc_data;
	word_t enc_cw;
	pos_t  enc_syn;
	word_t dec_cw;
	pos_t  dec_syn;
	logic  dec_found;
	word_t dec_fixed;
	word_t res_word;
	pos_t  res_pos;
	logic  res_found;

	// zero length reads as one, too long saturates to what fits
	always_comb begin
		cfg_m      = (data_bits == '0) ? pos_t'(1) : data_bits;
		cfg_m_clip = (cfg_m > pos_t'(M_MAX)) ? pos_t'(M_MAX) : cfg_m;
		cfg_n      = cfg_m_clip + pos_t'(parity_count(cfg_m_clip));
	end

	// config only moves when nothing is in flight
	assign cfg_ready = !valid_s1 && !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= RESET_M;
			n_q <= RESET_N;
		end else if (cfg_valid && cfg_ready) begin
			m_q <= cfg_m_clip;
			n_q <= cfg_n;
		end
	end

	// handshake: result register frees when empty or taken this cycle
	assign out_take = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && out_take;
	assign in_stall = valid_s1 && !out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= op_t'(operation);
			word_s1 <= word_in;
		end
	end

	// low-bit masks for data length and code length
	assign m_mask = ~({WORD_W{1'b1}} << m_q);
	assign n_mask = ~({WORD_W{1'b1}} << n_q);

	// encode: scatter, then parity bits take the syndrome of the data positions
	always_comb begin
		enc_data = word_s1 & m_mask;
		enc_cw   = scatter(enc_data);
		enc_syn  = syndrome(enc_cw);
		for (int j = 0; j < POS_W; j++)
			enc_cw[(1 << j) - 1] = enc_syn[j];
	end

	// decode: flip the named position if it lies inside the codeword
	always_comb begin
		dec_cw    = word_s1 & n_mask;
		dec_syn   = syndrome(dec_cw);
		dec_found = (dec_syn != '0);
		dec_fixed = dec_cw;
		if (dec_found && (dec_syn <= n_q))
			dec_fixed = dec_cw ^ (word_t'(1) << (dec_syn - pos_t'(1)));
	end

	always_comb begin
		case (op_s1)
			OP_ENCODE: begin
				res_word  = enc_cw;
				res_pos   = '0;
				res_found = 1'b0;
			end
			OP_DECODE: begin
				res_word  = dec_fixed;
				res_pos   = dec_syn;
				res_found = dec_found;
			end
			default: begin
				res_word  = '0;
				res_pos   = '0;
				res_found = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			word_q  <= res_word;
			pos_q   <= res_pos;
			found_q <= res_found;
		end
	end

	assign out_valid      = out_valid_q;
	assign word_out       = word_q;
	assign error_position = pos_q;
	assign error_found    = found_q;

	// every delivered word is a valid codeword unless the error lay outside it
	`HEC_ASSERT_IMPL(a_clean_codeword, out_valid_q && (pos_q <= n_q), syndrome(word_q) == '0)
	// found flag agrees with a nonzero position
	`HEC_ASSERT_IMPL(a_found_pos, out_valid_q, found_q == (pos_q != '0))
	// input stalls only when both registers hold items
	`HEC_ASSERT_IMPL(a_stall_cause, in_stall, valid_s1 && out_valid_q && out_stall)
	// stored lengths stay consistent
	`HEC_ASSERT_IMPL(a_cfg_lengths, 1'b1, (m_q != '0) && (n_q > m_q))
	// an accepted config write leaves the block idle next cycle
	`HEC_ASSERT_NEXT(a_cfg_idle, cfg_valid && cfg_ready && !in_valid, !out_valid_q)

endmodule

`default_nettype wire
